@@ hw/rtl/mpfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mpfs_pkg
// Shared constants and types for the streaming max pooling unit.
// ----------------------------------------------------------------------------
package mpfs_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_KERNEL_SIZE   = 2'd0,
		REG_IN_HEIGHT     = 2'd1,
		REG_IN_WIDTH      = 2'd2,
		REG_CHANNEL_COUNT = 2'd3
	} reg_idx_t;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;

	// register field widths
	localparam int KSIZE_BITS  = 4;
	localparam int HEIGHT_BITS = 11;
	localparam int WIDTH_BITS  = 11;
	localparam int CHCNT_BITS  = 13;

	// register reset values
	localparam logic [KSIZE_BITS-1:0]  KSIZE_RST  = 4'd2;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 11'd28;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 11'd28;
	localparam logic [CHCNT_BITS-1:0]  CHCNT_RST  = 13'd1;

	// fixed bounds of the plane and tensor
	localparam int MAX_HEIGHT   = 1024;
	localparam int MAX_CHANNELS = 4096;
	localparam int ROW_BITS     = 10;
	localparam int CHAN_BITS    = 12;

	// default module parameters
	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_MAX_KERNEL  = 8;
	localparam int DEF_SAMPLE_BITS = 16;

endpackage

@@ hw/rtl/mpfs_cfg.sv @@
// ----------------------------------------------------------------------------
// mpfs_cfg
// Configuration registers with range clamping and a restart strobe.
// ----------------------------------------------------------------------------
module mpfs_cfg import mpfs_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = DEF_MAX_KERNEL,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int KW = $clog2(MAX_KERNEL + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                     restart,
	output logic [KW-1:0]            kernel,
	output logic [HEIGHT_BITS-1:0]   height,
	output logic [WW-1:0]            width,
	output logic [CHCNT_BITS-1:0]    channels
);

	logic [KSIZE_BITS-1:0]  ksize_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [WIDTH_BITS-1:0]  width_q;
	logic [CHCNT_BITS-1:0]  chcnt_q;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q  <= KSIZE_RST;
			height_q <= HEIGHT_RST;
			width_q  <= WIDTH_RST;
			chcnt_q  <= CHCNT_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KERNEL_SIZE:   ksize_q  <= cfg_data[KSIZE_BITS-1:0];
				REG_IN_HEIGHT:     height_q <= cfg_data[HEIGHT_BITS-1:0];
				REG_IN_WIDTH:      width_q  <= cfg_data[WIDTH_BITS-1:0];
				REG_CHANNEL_COUNT: chcnt_q  <= cfg_data[CHCNT_BITS-1:0];
				default:           ksize_q  <= ksize_q;
			endcase
		end
	end

	// clamp each register into 1..bound
	always_comb begin
		if (ksize_q == '0)
			kernel = KW'(1);
		else if (32'(ksize_q) > MAX_KERNEL)
			kernel = KW'(MAX_KERNEL);
		else
			kernel = KW'(ksize_q);

		if (height_q == '0)
			height = HEIGHT_BITS'(1);
		else if (32'(height_q) > MAX_HEIGHT)
			height = HEIGHT_BITS'(MAX_HEIGHT);
		else
			height = height_q;

		if (width_q == '0)
			width = WW'(1);
		else if (32'(width_q) > MAX_WIDTH)
			width = WW'(MAX_WIDTH);
		else
			width = WW'(width_q);

		if (chcnt_q == '0)
			channels = CHCNT_BITS'(1);
		else if (32'(chcnt_q) > MAX_CHANNELS)
			channels = CHCNT_BITS'(MAX_CHANNELS);
		else
			channels = chcnt_q;
	end

endmodule

@@ hw/rtl/max_pool_forward_stream_unit.sv @@
// ----------------------------------------------------------------------------
// max_pool_forward_stream_unit
// Streaming non-overlapping K x K max pooling over a C x H x W tensor.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: sample_value
//  m_axis    out  m_axis_tvalid/tready       tdata: pooled_value, tlast: end_of_plane,
//                                            tuser: end_of_tensor
//  cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
//  One sample per cycle sustained. A sample is counted in stage 0, where the
//  per-window-column store is read; stage 1 folds and writes the store back
//  and loads the output register, so a result passes stage 1 and then the
//  output register. The store read-modify-write is the only loop and sets
//  the rate; a same-entry overlap is forwarded. Reset needs no store
//  clearing: the first row of every window row overwrites its entries. A
//  stalled output holds stage 1 and then the input.
//
module max_pool_forward_stream_unit import mpfs_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_KERNEL  = DEF_MAX_KERNEL,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// sample_value
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// pooled_value
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
	output logic                                 m_axis_tlast,
	// end_of_tensor
	output logic                                 m_axis_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]              cfg_index,
	input  logic [CFG_DATA_BITS-1:0]             cfg_data
);

	localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int KW = $clog2(MAX_KERNEL + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                   restart;
	logic [KW-1:0]          k_c;
	logic [HEIGHT_BITS-1:0] h_c;
	logic [WW-1:0]          w_c;
	logic [CHCNT_BITS-1:0]  c_c;

	mpfs_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_KERNEL (MAX_KERNEL)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (restart),
		.kernel    (k_c),
		.height    (h_c),
		.width     (w_c),
		.channels  (c_c)
	);

	// position state
	logic [WW-1:0]          col_q;
	logic [ROW_BITS-1:0]    row_q;
	logic [CHAN_BITS-1:0]   chan_q;
	logic [KW-1:0]          ocol_q;
	logic [KW-1:0]          orow_q;
	logic [AW-1:0]          wcol_q;
	logic                   col_full_q;
	logic                   row_full_q;
	logic [SAMPLE_BITS-1:0] rmax_q;

	// stage 1
	logic                   v_s1;
	logic                   ovr_s1;
	logic                   emit_s1;
	logic                   byp_s1;
	logic                   eop_s1;
	logic                   eot_s1;
	logic [AW-1:0]          addr_s1;
	logic [SAMPLE_BITS-1:0] rmax_s1;

	// store and output
	logic [SAMPLE_BITS-1:0] store_mem [MAX_WIDTH];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [SAMPLE_BITS-1:0] wdata_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] pooled_q;
	logic                   eop_q;
	logic                   eot_q;

	logic                   accept;
	logic                   s1_fire;
	logic                   out_free;
	logic [SAMPLE_BITS-1:0] x;
	logic [WW-1:0]          col_rem;
	logic [HEIGHT_BITS-1:0] row_rem;
	logic                   col_full;
	logic                   row_full;
	logic                   in_region;
	logic                   ocol_last;
	logic                   orow_last;
	logic                   col_last;
	logic                   row_last;
	logic                   chan_last;
	logic                   fold;
	logic                   rd_en;
	logic [SAMPLE_BITS-1:0] rmax_next;
	logic [SAMPLE_BITS-1:0] old_val;
	logic [SAMPLE_BITS-1:0] fold_val;

	assign x         = s_axis_tdata[SAMPLE_BITS-1:0];
	assign out_free  = !out_valid_q || m_axis_tready;
	assign s1_fire   = v_s1 && (!emit_s1 || out_free);
	assign s_axis_tready = !v_s1 || s1_fire;
	assign accept    = s_axis_tvalid && s_axis_tready;

	// window fullness is decided where each window starts
	assign col_rem   = w_c - col_q;
	assign row_rem   = h_c - HEIGHT_BITS'(row_q);
	assign col_full  = (ocol_q == '0) ? (32'(col_rem) >= 32'(k_c)) : col_full_q;
	assign row_full  = (orow_q == '0) ? (32'(row_rem) >= 32'(k_c)) : row_full_q;
	assign in_region = col_full && row_full;

	assign ocol_last = 32'(ocol_q) + 32'd1 >= 32'(k_c);
	assign orow_last = 32'(orow_q) + 32'd1 >= 32'(k_c);
	assign col_last  = 32'(col_q) + 32'd1 >= 32'(w_c);
	assign row_last  = 32'(row_q) + 32'd1 >= 32'(h_c);
	assign chan_last = 32'(chan_q) + 32'd1 >= 32'(c_c);

	assign fold      = in_region && ocol_last;
	assign rd_en     = accept && fold && (orow_q != '0);

	assign rmax_next = ((ocol_q == '0) || ($signed(x) > $signed(rmax_q))) ? x : rmax_q;

	assign old_val   = byp_s1 ? wdata_q : rd_q;
	assign fold_val  = (ovr_s1 || ($signed(rmax_s1) > $signed(old_val))) ? rmax_s1 : old_val;

	// position counters and running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			chan_q     <= '0;
			ocol_q     <= '0;
			orow_q     <= '0;
			wcol_q     <= '0;
			col_full_q <= 1'b0;
			row_full_q <= 1'b0;
			rmax_q     <= MOST_NEG;
		end else if (restart) begin
			col_q      <= '0;
			row_q      <= '0;
			chan_q     <= '0;
			ocol_q     <= '0;
			orow_q     <= '0;
			wcol_q     <= '0;
			col_full_q <= 1'b0;
			row_full_q <= 1'b0;
			rmax_q     <= MOST_NEG;
		end else if (accept) begin
			col_full_q <= col_full;
			row_full_q <= row_full;
			if (in_region)
				rmax_q <= rmax_next;
			if (col_last) begin
				col_q  <= '0;
				ocol_q <= '0;
				wcol_q <= '0;
				if (row_last) begin
					row_q  <= '0;
					orow_q <= '0;
					chan_q <= chan_last ? '0 : chan_q + 1'b1;
				end else begin
					row_q  <= row_q + 1'b1;
					orow_q <= orow_last ? '0 : orow_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (ocol_last) begin
					ocol_q <= '0;
					wcol_q <= wcol_q + 1'b1;
				end else begin
					ocol_q <= ocol_q + 1'b1;
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= fold;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ovr_s1  <= (orow_q == '0);
			emit_s1 <= orow_last;
			addr_s1 <= wcol_q;
			rmax_s1 <= rmax_next;
			eop_s1  <= (32'(col_rem) <= 32'(k_c)) && (32'(row_rem) <= 32'(k_c));
			eot_s1  <= (32'(col_rem) <= 32'(k_c)) && (32'(row_rem) <= 32'(k_c)) && chan_last;
			// forward a write-back that lands in the same cycle as this read
			byp_s1  <= s1_fire && (addr_s1 == wcol_q);
		end
	end

	// partial maximum store: read in stage 0, write back in stage 1
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= store_mem[wcol_q];
		if (s1_fire) begin
			store_mem[addr_s1] <= fold_val;
			wdata_q            <= fold_val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_s1) begin
			pooled_q <= fold_val;
			eop_q    <= eop_s1;
			eot_q    <= eot_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DW'(pooled_q);
	assign m_axis_tlast  = eop_q;
	assign m_axis_tuser  = eot_q;

`ifndef NO_ASSERTIONS
	a_eot_has_eop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("end of tensor without end of plane");

	a_pos_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < 32'(w_c)) && (32'(row_q) < 32'(h_c)) && (32'(chan_q) < 32'(c_c)))
		else $error("position counter out of range");

	a_offset_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(ocol_q) < 32'(k_c)) && (32'(orow_q) < 32'(k_c)))
		else $error("window offset out of range");

	a_s1_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_fire |-> out_valid_q && !m_axis_tready)
		else $error("stage 1 held without a blocked output");
`endif

endmodule

@@ verif/tb_max_pool_forward_stream_unit.sv @@
// ----------------------------------------------------------------------------
// tb_max_pool_forward_stream_unit
// Self-checking bench for the streaming K x K max pooling unit. A directed
// table covers sample extremes, clamped register values and windows larger
// than the plane. Random phases follow: a new shape per phase, random
// samples, random gaps on both streams, one long output stall and a very
// wide plane. An in-bench model of the pooling predicts every result, and
// each output beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_max_pool_forward_stream_unit;
	import mpfs_pkg::*;

	localparam int TDATA_W      = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE       = 8;
	localparam int LONG_HOLD    = 200;
	localparam int RANDOM_ITEMS = 1500;
	localparam int PLAN_ROWS    = 34;

	typedef struct packed {
		logic [15:0] value;
		logic        plane_end;
		logic        tensor_end;
	} pooled_t;

	typedef enum {ROW_WRITE, ROW_SAMPLE} plan_kind_t;
	typedef enum {CHK_MODEL, CHK_NONE, CHK_GIVEN} plan_check_t;

	typedef struct {
		plan_kind_t                kind;
		reg_idx_t                  idx;
		logic [CFG_DATA_BITS-1:0]  data;
		logic [15:0]               sample;
		plan_check_t               chk;
		pooled_t                   want;
	} plan_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [TDATA_W-1:0]        s_axis_tdata;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [TDATA_W-1:0]        m_axis_tdata;
	logic                      m_axis_tlast;
	logic                      m_axis_tuser;
	logic                      cfg_valid;
	logic                      cfg_ready;
	reg_idx_t                  cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// pooling model state
	logic [KSIZE_BITS-1:0]     shadow_ksize;
	logic [HEIGHT_BITS-1:0]    shadow_height;
	logic [WIDTH_BITS-1:0]     shadow_width;
	logic [CHCNT_BITS-1:0]     shadow_chans;
	logic signed [15:0]        window_col_max [DEF_MAX_WIDTH];
	logic signed [15:0]        row_run_max;
	int unsigned               col_pos, row_pos, chan_pos, win_col_ofs, win_row_ofs;

	pooled_t                   pending_pools [$];
	int                        mismatch_count = 0;
	int                        cycle_count = 0;
	int unsigned               send_gap_max = 19;
	int unsigned               recv_gap_max = 5;
	int unsigned               random_samples = 0;
	bit                        hold_output = 1'b0;

	plan_row_t directed_plan [PLAN_ROWS] = '{
		// one-sample windows on a 1x1 plane: every sample comes straight back
		'{ROW_WRITE,  REG_KERNEL_SIZE,   13'd1,    16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_IN_HEIGHT,     13'd1,    16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_IN_WIDTH,      13'd1,    16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_CHANNEL_COUNT, 13'd1,    16'h0000, CHK_MODEL, '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h7fff, CHK_GIVEN, {16'h7fff, 2'b11}},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h8000, CHK_GIVEN, {16'h8000, 2'b11}},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h0000, CHK_GIVEN, {16'h0000, 2'b11}},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'hffff, CHK_GIVEN, {16'hffff, 2'b11}},
		// zero kernel acts as one
		'{ROW_WRITE,  REG_KERNEL_SIZE,   13'd0,    16'h0000, CHK_MODEL, '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h1234, CHK_GIVEN, {16'h1234, 2'b11}},
		// zero height, oversize kernel: window never fits
		'{ROW_WRITE,  REG_IN_HEIGHT,     13'd0,    16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_KERNEL_SIZE,   13'd15,   16'h0000, CHK_MODEL, '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h5555, CHK_NONE,  '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'haaaa, CHK_NONE,  '0},
		// two 2x2 planes, one window each
		'{ROW_WRITE,  REG_KERNEL_SIZE,   13'd2,    16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_IN_HEIGHT,     13'd2,    16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_IN_WIDTH,      13'd2,    16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_CHANNEL_COUNT, 13'd2,    16'h0000, CHK_MODEL, '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h8000, CHK_NONE,  '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h8001, CHK_NONE,  '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h7fff, CHK_NONE,  '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h0000, CHK_GIVEN, {16'h7fff, 2'b10}},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h8000, CHK_NONE,  '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h8000, CHK_NONE,  '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h8000, CHK_NONE,  '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h8000, CHK_GIVEN, {16'h8000, 2'b11}},
		// zero width and zero channel count: plane narrower than the window
		'{ROW_WRITE,  REG_IN_WIDTH,      13'd0,    16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_CHANNEL_COUNT, 13'd0,    16'h0000, CHK_MODEL, '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h0100, CHK_NONE,  '0},
		// all-ones registers saturate to the bounds
		'{ROW_WRITE,  REG_CHANNEL_COUNT, 13'd8191, 16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_IN_HEIGHT,     13'd2047, 16'h0000, CHK_MODEL, '0},
		'{ROW_WRITE,  REG_IN_WIDTH,      13'd2047, 16'h0000, CHK_MODEL, '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h8000, CHK_MODEL, '0},
		'{ROW_SAMPLE, REG_KERNEL_SIZE,   13'd0,    16'h7fff, CHK_MODEL, '0}
	};

	max_pool_forward_stream_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("max_pool_forward_stream_unit test failed");
			$finish;
		end
	end

	function automatic int unsigned clamp_u(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic void restart_tensor();
		row_run_max = 16'sh8000;
		col_pos     = 0;
		row_pos     = 0;
		chan_pos    = 0;
		win_col_ofs = 0;
		win_row_ofs = 0;
	endfunction

	function automatic void apply_reg_write(input reg_idx_t idx,
			input logic [CFG_DATA_BITS-1:0] data);
		case (idx)
			REG_KERNEL_SIZE:   shadow_ksize  = data[KSIZE_BITS-1:0];
			REG_IN_HEIGHT:     shadow_height = data[HEIGHT_BITS-1:0];
			REG_IN_WIDTH:      shadow_width  = data[WIDTH_BITS-1:0];
			REG_CHANNEL_COUNT: shadow_chans  = data[CHCNT_BITS-1:0];
		endcase
		restart_tensor();
	endfunction

	// advance the pooling state by one sample; return 1 when a window closes
	function automatic bit predict_pool(input logic signed [15:0] x, output pooled_t res);
		int unsigned k, h, w, c, use_w, use_h, wc;
		bit made;
		k     = clamp_u(shadow_ksize, 1, DEF_MAX_KERNEL);
		h     = clamp_u(shadow_height, 1, MAX_HEIGHT);
		w     = clamp_u(shadow_width, 1, DEF_MAX_WIDTH);
		c     = clamp_u(shadow_chans, 1, MAX_CHANNELS);
		use_w = (w / k) * k;
		use_h = (h / k) * k;
		made  = 1'b0;
		res   = '0;
		if (row_pos < use_h && col_pos < use_w) begin
			if (win_col_ofs == 0 || x > row_run_max)
				row_run_max = x;
			if (win_col_ofs + 1 >= k) begin
				wc = (col_pos / k) % DEF_MAX_WIDTH;
				// first row of a window row overwrites the column entry
				if (win_row_ofs == 0 || row_run_max > window_col_max[wc])
					window_col_max[wc] = row_run_max;
				if (win_row_ofs + 1 >= k) begin
					res.value      = window_col_max[wc];
					res.plane_end  = (row_pos + 1 == use_h) && (col_pos + 1 == use_w);
					res.tensor_end = res.plane_end && (chan_pos + 1 == c);
					made           = 1'b1;
				end
			end
		end
		win_col_ofs = (win_col_ofs + 1 >= k) ? 0 : win_col_ofs + 1;
		col_pos++;
		if (col_pos >= w) begin
			col_pos     = 0;
			win_col_ofs = 0;
			win_row_ofs = (win_row_ofs + 1 >= k) ? 0 : win_row_ofs + 1;
			row_pos++;
			if (row_pos >= h) begin
				row_pos     = 0;
				win_row_ofs = 0;
				chan_pos++;
				if (chan_pos >= c)
					chan_pos = 0;
			end
		end
		return made;
	endfunction

	function automatic int unsigned pick_extent(input int unsigned ke);
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, ke - 1);
		return ke * $urandom_range(1, (ke <= 3) ? 4 : 2) + $urandom_range(0, ke - 1);
	endfunction

	function automatic int unsigned pick_gap_max();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 3;
			default: return 19;
		endcase
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, val);
		@(negedge clk);
	endtask

	task automatic feed_sample(input logic [15:0] v, input plan_check_t chk,
			input pooled_t given);
		int unsigned gap;
		pooled_t res;
		bit made;
		gap = $urandom_range(0, send_gap_max);
		cfg_valid <= 1'b0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		made = predict_pool(v, res);
		if (chk == CHK_GIVEN)
			pending_pools.push_back(given);
		else if (chk == CHK_MODEL && made)
			pending_pools.push_back(res);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_pools.size() != 0);
	endtask

	// let trailing samples that close no window clear the pipeline
	task automatic settle_block();
		drain_results();
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_phase(input int unsigned phase);
		int unsigned k_reg, ke, h, w, c, n, tensor, first;
		logic [CFG_DATA_BITS-1:0] vals [4];
		logic [15:0] v;
		if (phase == 0) begin
			// a result per beat, so a stalled output backs up the input
			k_reg = 1; h = 4; w = 8; c = 2;
		end else if (phase == 2) begin
			// row wider than the store: width saturates
			k_reg = 1; h = 1; w = $urandom_range(DEF_MAX_WIDTH + 1, 2047); c = 1;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: k_reg = $urandom_range(1, 3);
				6, 7, 8:          k_reg = $urandom_range(4, DEF_MAX_KERNEL);
				default:          k_reg = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
			endcase
			ke = clamp_u(k_reg, 1, DEF_MAX_KERNEL);
			h  = pick_extent(ke);
			w  = pick_extent(ke);
			c  = $urandom_range(0, 3);
		end
		vals[REG_KERNEL_SIZE]   = CFG_DATA_BITS'(k_reg);
		vals[REG_IN_HEIGHT]     = CFG_DATA_BITS'(h);
		vals[REG_IN_WIDTH]      = CFG_DATA_BITS'(w);
		vals[REG_CHANNEL_COUNT] = CFG_DATA_BITS'(c);
		settle_block();
		first = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++)
			write_reg(reg_idx_t'((first + i) % 4), vals[(first + i) % 4]);
		tensor = clamp_u(h, 1, MAX_HEIGHT) * clamp_u(w, 1, DEF_MAX_WIDTH) *
			clamp_u(c, 1, MAX_CHANNELS);
		if (phase == 2)
			n = DEF_MAX_WIDTH + 16;
		else if (phase == 0)
			n = 2 * tensor;
		else
			n = $urandom_range(1, (2 * tensor > 300) ? 300 : 2 * tensor);
		send_gap_max = (phase == 0 || phase == 2) ? 0 : pick_gap_max();
		if (phase == 0)
			hold_output = 1'b1;
		for (int i = 0; i < n; i++) begin
			v = 16'($urandom);
			if ($urandom_range(0, 15) == 0)
				v = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			feed_sample(v, CHK_MODEL, '0);
			if ((phase == 0 && i == n / 2) || $urandom_range(0, 199) == 0)
				drain_results();
		end
		random_samples += n;
	endtask

	initial begin : pool_sink
		int unsigned gap;
		pooled_t got, want;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, recv_gap_max);
			if (hold_output) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_output = 1'b0;
			end else if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got = {m_axis_tdata[15:0], m_axis_tlast, m_axis_tuser};
			if (pending_pools.size() == 0) begin
				$error("pooled beat with nothing pending: pooled_value %h", got.value);
				mismatch_count++;
			end else begin
				want = pending_pools.pop_front();
				if (got.value !== want.value) begin
					$error("pooled_value: expected %h, got %h", want.value, got.value);
					mismatch_count++;
				end
				if (got.plane_end !== want.plane_end) begin
					$error("end_of_plane: expected %b, got %b", want.plane_end, got.plane_end);
					mismatch_count++;
				end
				if (got.tensor_end !== want.tensor_end) begin
					$error("end_of_tensor: expected %b, got %b", want.tensor_end,
						got.tensor_end);
					mismatch_count++;
				end
			end
			if ($urandom_range(0, 49) == 0)
				recv_gap_max = pick_gap_max();
			@(negedge clk);
		end
	end

	initial begin
		bit streaming;
		int unsigned phase;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_KERNEL_SIZE;
		cfg_data      = '0;
		shadow_ksize  = KSIZE_RST;
		shadow_height = HEIGHT_RST;
		shadow_width  = WIDTH_RST;
		shadow_chans  = CHCNT_RST;
		foreach (window_col_max[i])
			window_col_max[i] = 16'sh8000;
		restart_tensor();
		streaming = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (directed_plan[r].kind == ROW_WRITE) begin
				if (streaming)
					settle_block();
				streaming = 1'b0;
				write_reg(directed_plan[r].idx, directed_plan[r].data);
			end else begin
				streaming = 1'b1;
				feed_sample(directed_plan[r].sample, directed_plan[r].chk,
					directed_plan[r].want);
			end
		end

		phase = 0;
		while (random_samples < RANDOM_ITEMS) begin
			run_phase(phase);
			phase++;
		end

		settle_block();
		if (mismatch_count == 0)
			$display("max_pool_forward_stream_unit test passed");
		else
			$display("max_pool_forward_stream_unit test failed");
		$finish;
	end

endmodule
